// ===== hdl/k_transaction_max_profit_defines.svh =====
// assertion macros shared by the rtl
`ifndef K_TRANSACTION_MAX_PROFIT_DEFINES_SVH
`define K_TRANSACTION_MAX_PROFIT_DEFINES_SVH

// same-cycle implication
`define KMP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kmp assertion failed");

// next-cycle implication
`define KMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kmp assertion failed");

`endif

// ===== hdl/kmp_pkg.sv =====
`default_nettype none

package kmp_pkg;

    localparam int MAX_TRANSACTIONS = 64;
    localparam int DEPTH            = MAX_TRANSACTIONS + 1;
    localparam int IDX_W            = $clog2(DEPTH);

    localparam int PRICE_W  = 16;
    localparam int VAL_W    = 32;
    localparam int PROFIT_W = 31;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t PROFIT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        val_t               hold_old;
        logic               hold_ok;
        val_t               flat_old;
        logic               flat_ok;
        val_t               flat_prev;
        logic               flat_prev_ok;
    } step_in_t;

    typedef struct packed {
        logic flat_wr;
        val_t flat_value;
        logic flat_valid;
        logic hold_wr;
        val_t hold_value;
    } step_res_t;

endpackage

`default_nettype wire

// ===== hdl/kmp_ram.sv =====
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/kmp_step_unit.sv =====
`default_nettype none

module kmp_step_unit (
    input  wire kmp_pkg::step_in_t  step_in,
    output kmp_pkg::step_res_t      step_res
);

    logic signed [kmp_pkg::VAL_W:0] sold_wide;
    kmp_pkg::val_t                  sold;
    kmp_pkg::val_t                  bought;
    logic                           flat_upd;
    logic                           hold_upd;

    always_comb begin
        sold_wide = $signed({step_in.hold_old[kmp_pkg::VAL_W-1], step_in.hold_old})
                  + $signed({{(kmp_pkg::VAL_W + 1 - kmp_pkg::PRICE_W){1'b0}}, step_in.price});
        if (sold_wide > $signed({1'b0, kmp_pkg::PROFIT_MAX})) begin
            sold = kmp_pkg::PROFIT_MAX;
        end else begin
            sold = sold_wide[kmp_pkg::VAL_W-1:0];
        end
        bought = step_in.flat_prev
               - $signed({{(kmp_pkg::VAL_W - kmp_pkg::PRICE_W){1'b0}}, step_in.price});

        flat_upd = step_in.hold_ok && (!step_in.flat_ok || (sold > step_in.flat_old));
        hold_upd = step_in.flat_prev_ok && (!step_in.hold_ok || (bought > step_in.hold_old));

        step_res.flat_wr    = flat_upd;
        step_res.flat_value = flat_upd ? sold : step_in.flat_old;
        step_res.flat_valid = flat_upd || step_in.flat_ok;
        step_res.hold_wr    = hold_upd;
        step_res.hold_value = bought;
    end

endmodule

`default_nettype wire

// ===== hdl/k_transaction_max_profit.sv =====
// channel   direction  signals                                 word
// s_        in         s_valid s_ready s_price s_last          one day's price
// m_        out        m_valid m_ready m_profit                result on last day
// cfg_      in         cfg_valid cfg_ready cfg_max_transactions  transaction limit
//
// a word visits entries k..1, k the limit in force (capped at 64), one entry per cycle
// through the shared sell/buy add-compare unit; a zero limit skips straight to the finish
// aresetn (synchronous) clears all hold valid bits, flat ones but entry 0; limit set to 2
// s_ready is low while a word is in work; a waiting result stalls only the next last day
`default_nettype none
`include "k_transaction_max_profit_defines.svh"

module k_transaction_max_profit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kmp_pkg::PRICE_W-1:0]   s_price,
    input  wire logic                          s_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [kmp_pkg::PROFIT_W-1:0]  m_profit,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kmp_pkg::CFG_W-1:0]     cfg_max_transactions
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_READ,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef logic [kmp_pkg::IDX_W-1:0] idx_t;
    typedef logic [kmp_pkg::DEPTH-1:0] okv_t;

    state_t                          state_reg, state_next;
    idx_t                            j_reg, j_next;
    idx_t                            k_reg, k_next;
    logic [kmp_pkg::PRICE_W-1:0]     price_reg, price_next;
    logic                            last_reg, last_next;
    logic [kmp_pkg::CFG_W-1:0]       cfg_reg, cfg_next;
    kmp_pkg::val_t                   carry_reg, carry_next;
    kmp_pkg::val_t                   best_reg, best_next;
    logic                            m_valid_reg, m_valid_next;
    logic [kmp_pkg::PROFIT_W-1:0]    m_profit_reg, m_profit_next;
    okv_t                            flat_ok_reg, flat_ok_next;
    okv_t                            hold_ok_reg, hold_ok_next;

    idx_t                            limit;
    idx_t                            j_dec;
    idx_t                            flat_raddr;
    idx_t                            hold_raddr;
    kmp_pkg::val_t                   flat_rdata;
    kmp_pkg::val_t                   hold_rdata;
    logic                            run;
    kmp_pkg::step_in_t               step_in;
    kmp_pkg::step_res_t              step_res;

    assign run   = (state_reg == ST_RUN);
    assign j_dec = j_reg - idx_t'(1);

    assign limit = (int'(cfg_reg) > kmp_pkg::MAX_TRANSACTIONS)
                 ? idx_t'(kmp_pkg::MAX_TRANSACTIONS)
                 : idx_t'(cfg_reg);

    always_comb begin
        step_in.price        = price_reg;
        step_in.hold_old     = hold_rdata;
        step_in.hold_ok      = hold_ok_reg[j_reg];
        step_in.flat_old     = carry_reg;
        step_in.flat_ok      = flat_ok_reg[j_reg];
        step_in.flat_prev    = (j_reg == idx_t'(1)) ? '0 : flat_rdata;
        step_in.flat_prev_ok = flat_ok_reg[j_dec];
    end

    kmp_step_unit u_step (
        .step_in  (step_in),
        .step_res (step_res)
    );

    kmp_ram #(
        .WIDTH (kmp_pkg::VAL_W),
        .DEPTH (kmp_pkg::DEPTH)
    ) u_flat_ram (
        .clk   (aclk),
        .we    (run && step_res.flat_wr),
        .waddr (j_reg),
        .wdata (step_res.flat_value),
        .raddr (flat_raddr),
        .rdata (flat_rdata)
    );

    kmp_ram #(
        .WIDTH (kmp_pkg::VAL_W),
        .DEPTH (kmp_pkg::DEPTH)
    ) u_hold_ram (
        .clk   (aclk),
        .we    (run && step_res.hold_wr),
        .waddr (j_reg),
        .wdata (step_res.hold_value),
        .raddr (hold_raddr),
        .rdata (hold_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        price_next    = price_reg;
        last_next     = last_reg;
        cfg_next      = cfg_reg;
        carry_next    = carry_reg;
        best_next     = best_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_profit_next = m_profit_reg;
        flat_ok_next  = flat_ok_reg;
        hold_ok_next  = hold_ok_reg;
        flat_raddr    = j_reg;
        hold_raddr    = j_reg;

        if (cfg_valid) begin
            cfg_next = cfg_max_transactions;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    price_next = s_price;
                    last_next  = s_last;
                    k_next     = limit;
                    j_next     = limit;
                    best_next  = '0;
                    state_next = (limit == '0) ? ST_FINISH : ST_PRIME;
                end
            end
            ST_PRIME: begin
                flat_raddr = j_reg;
                state_next = ST_READ;
            end
            ST_READ: begin
                hold_raddr = j_reg;
                flat_raddr = j_dec;
                carry_next = flat_rdata;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                hold_raddr = j_dec;
                flat_raddr = (j_reg >= idx_t'(2)) ? (j_reg - idx_t'(2)) : '0;
                carry_next = flat_rdata;
                if (step_res.flat_wr) begin
                    flat_ok_next[j_reg] = 1'b1;
                end
                if (step_res.hold_wr) begin
                    hold_ok_next[j_reg] = 1'b1;
                end
                if (step_res.flat_valid && (step_res.flat_value > best_reg)) begin
                    best_next = step_res.flat_value;
                end
                if (j_reg == idx_t'(1)) begin
                    state_next = ST_FINISH;
                end else begin
                    j_next = j_dec;
                end
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_profit_next = best_reg[kmp_pkg::PROFIT_W-1:0];
                    flat_ok_next  = okv_t'(1);
                    hold_ok_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= kmp_pkg::CFG_RESET;
            m_valid_reg <= 1'b0;
            flat_ok_reg <= okv_t'(1);
            hold_ok_reg <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            last_reg    <= 1'b0;
            best_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
            flat_ok_reg <= flat_ok_next;
            hold_ok_reg <= hold_ok_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            last_reg    <= last_next;
            best_reg    <= best_next;
        end
        price_reg    <= price_next;
        carry_reg    <= carry_next;
        m_profit_reg <= m_profit_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_profit  = m_profit_reg;
    assign cfg_ready = 1'b1;

    `KMP_ASSERT_IMPL(a_flat_zero_valid, aclk, aresetn, 1'b1, flat_ok_reg[0])
    `KMP_ASSERT_IMPL(a_run_index, aclk, aresetn, run, (j_reg != '0) && (j_reg <= k_reg))
    `KMP_ASSERT_IMPL(a_best_nonneg, aclk, aresetn, 1'b1, !best_reg[kmp_pkg::VAL_W-1])
    `KMP_ASSERT_NEXT(a_clear_on_result, aclk, aresetn,
        (state_reg == ST_FINISH) && last_reg && (!m_valid_reg || m_ready),
        m_valid_reg && (hold_ok_reg == '0) && (flat_ok_reg == okv_t'(1)))

endmodule

`default_nettype wire
